FILE: design/haar_dwt_approximation_unit_macros.svh
// Assertion shorthands used by the checker of this block.
`ifndef HAAR_DWT_APPROXIMATION_UNIT_MACROS_SVH
`define HAAR_DWT_APPROXIMATION_UNIT_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define HAAR_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("haar check failed: same-cycle rule");

// Next-cycle implication, off while reset is high.
`define HAAR_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("haar check failed: next-cycle rule");

`endif

FILE: design/haar_pkg.sv
package haar_pkg;

   // result word format, Q19.4
   localparam int COEF_W   = 24;
   localparam int COEF_MAX = 8388607;
   localparam int COEF_MIN = -8388608;

   // 1/sqrt2 in Q1.17
   localparam int HAAR_K     = 92682;
   localparam int HAAR_K_W   = 17;
   localparam int HAAR_SHIFT = 17;

   // configuration port
   localparam int CFG_W     = 3;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] REG_LENGTH_LOG2 = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_LEVEL       = 2'd1;

   localparam logic [CFG_W-1:0] LENGTH_LOG2_RESET = 3'd6;
   localparam logic [CFG_W-1:0] LEVEL_RESET       = 3'd1;

endpackage

FILE: design/haar_if.sv
// Sample channel: one sample word per handshake.
interface haar_req_if
   import haar_pkg::*;
#(
   parameter int SAMPLE_BITS = 16
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

// Result channel: one coefficient word per handshake.
interface haar_rsp_if
   import haar_pkg::*;
;
   logic                     valid;
   logic                     ready;
   logic signed [COEF_W-1:0] coefficient;
   logic                     level_error;
   logic                     last;

   modport source (output valid, output coefficient, output level_error, output last,
                   input ready);
   modport sink   (input valid, input coefficient, input level_error, input last,
                   output ready);
endinterface

FILE: design/haar_dwt_approximation_unit.sv
// Frame of n = 2^length_log2 samples: the n samples are loaded (one word per cycle),
// then each Haar round passes its pairs through the 4-deep read/sum/multiply/write
// pipeline on the work memory, then the n words are emitted (one word per cycle while
// the result channel does not stall); the memory read-port pair sets the pace of a round.
// Synchronous active-high reset: control registers return to length_log2 = 6, level = 1,
// empty frame; the work memory is not cleared.
module haar_dwt_approximation_unit
   import haar_pkg::*;
#(
   parameter int MAX_LEN     = 64,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   haar_req_if.sink             req_ch,
   haar_rsp_if.source           rsp_ch,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata
);

   // largest supported log2 length, 1..6
   localparam int CAP_RAW = $clog2(MAX_LEN + 1) - 1;
   localparam int CAP     = (CAP_RAW > 6) ? 6 : ((CAP_RAW < 1) ? 1 : CAP_RAW);
   localparam int DEPTH   = 1 << CAP;
   localparam int ADDR_W  = CAP;
   localparam int CNT_W   = CAP + 1;
   localparam int LDW     = (SAMPLE_BITS + 4 > COEF_W) ? SAMPLE_BITS + 4 : COEF_W;
   localparam int PROD_W  = COEF_W + 1 + HAAR_K_W + 1;
   localparam int AVG_W   = PROD_W - HAAR_SHIFT;

   localparam logic signed [HAAR_K_W:0] K_S = (HAAR_K_W + 1)'(HAAR_K);

   typedef enum logic [4:0] {
      ST_LOAD  = 5'b00001,
      ST_PASS  = 5'b00010,
      ST_DRAIN = 5'b00100,
      ST_EMIT  = 5'b01000,
      ST_ERR   = 5'b10000
   } state_type;

   state_type             state_ff, state_in;
   logic [CFG_W-1:0]      len_log2_ff, len_log2_in;
   logic [CFG_W-1:0]      level_ff, level_in;
   logic [ADDR_W-1:0]     load_cnt_ff, load_cnt_in;
   logic [CNT_W-1:0]      n_ff, n_in;
   logic [CNT_W-1:0]      keep_ff, keep_in;
   logic [CFG_W-1:0]      lv_ff, lv_in;
   logic [CFG_W-1:0]      rnd_ff, rnd_in;
   logic [ADDR_W-1:0]     seg_ff, seg_in;
   logic [ADDR_W-1:0]     pair_ff, pair_in;
   logic [ADDR_W-1:0]     emit_ff, emit_in;
   logic                  v1_ff, v2_ff, v3_ff;
   logic [ADDR_W-1:0]     wa1_ff, wa2_ff, wa3_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_zero_ff, rsp_zero_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic                  rsp_err_ff, rsp_err_in;

   logic signed [COEF_W-1:0] store_mem [DEPTH];
   logic signed [COEF_W-1:0] rd_a_ff, rd_b_ff;
   logic signed [COEF_W:0]   sum_ff;
   logic signed [PROD_W-1:0] prod_ff;

   logic                  req_acc;
   logic                  frame_done;
   logic [CFG_W-1:0]      lg_eff;
   logic [CNT_W-1:0]      n_cur;
   logic                  pass_issue;
   logic                  emit_issue;
   logic                  out_free;
   logic                  pipe_busy;
   logic [ADDR_W-1:0]     rd_a_addr, rd_b_addr;
   logic                  mem_we;
   logic [ADDR_W-1:0]     mem_wa;
   logic signed [COEF_W-1:0] mem_wd;
   logic signed [LDW-1:0]    ld_ext;
   logic signed [COEF_W-1:0] ld_val;
   logic signed [PROD_W-1:0] rnd_sum;
   logic signed [AVG_W-1:0]  avg_wide;
   logic signed [COEF_W-1:0] avg_val;

   // effective frame length from the current configuration
   always_comb begin
      if (len_log2_ff < CFG_W'(1)) begin
         lg_eff = CFG_W'(1);
      end else if (len_log2_ff > CFG_W'(CAP)) begin
         lg_eff = CFG_W'(CAP);
      end else begin
         lg_eff = len_log2_ff;
      end
      n_cur = CNT_W'(1) << lg_eff;
   end

   assign req_acc    = req_ch.valid && req_ch.ready;
   assign frame_done = req_acc && (({1'b0, load_cnt_ff} + CNT_W'(1)) >= n_cur);
   assign out_free   = !rsp_valid_ff || rsp_ch.ready;
   assign pass_issue = (state_ff == ST_PASS) && !rsp_valid_ff;
   assign emit_issue = (state_ff == ST_EMIT) && out_free;
   assign pipe_busy  = v1_ff || v2_ff || v3_ff;

   // sample to Q19.4 with saturation
   always_comb begin
      ld_ext = LDW'(signed'({req_ch.sample, 4'b0000}));
      if (ld_ext > LDW'(COEF_MAX)) begin
         ld_val = COEF_W'(COEF_MAX);
      end else if (ld_ext < LDW'(COEF_MIN)) begin
         ld_val = COEF_W'(COEF_MIN);
      end else begin
         ld_val = COEF_W'(ld_ext);
      end
   end

   // round to nearest, ties up, then saturate
   always_comb begin
      rnd_sum  = prod_ff + PROD_W'(1 << (HAAR_SHIFT - 1));
      avg_wide = signed'(rnd_sum[PROD_W-1:HAAR_SHIFT]);
      if (avg_wide > AVG_W'(COEF_MAX)) begin
         avg_val = COEF_W'(COEF_MAX);
      end else if (avg_wide < AVG_W'(COEF_MIN)) begin
         avg_val = COEF_W'(COEF_MIN);
      end else begin
         avg_val = COEF_W'(avg_wide);
      end
   end

   // memory port selection
   assign rd_a_addr = (state_ff == ST_EMIT) ? emit_ff : ADDR_W'({pair_ff, 1'b0});
   assign rd_b_addr = ADDR_W'({pair_ff, 1'b1});
   assign mem_we    = req_acc || v3_ff;
   assign mem_wa    = v3_ff ? wa3_ff : load_cnt_ff;
   assign mem_wd    = v3_ff ? avg_val : ld_val;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_wa] <= mem_wd;
      end
      if (pass_issue || emit_issue) begin
         rd_a_ff <= store_mem[rd_a_addr];
      end
      if (pass_issue) begin
         rd_b_ff <= store_mem[rd_b_addr];
      end
   end

   // averaging pipeline payload
   always_ff @(posedge clock) begin
      sum_ff  <= (COEF_W + 1)'(rd_a_ff) + (COEF_W + 1)'(rd_b_ff);
      prod_ff <= sum_ff * K_S;
      wa1_ff  <= pair_ff;
      wa2_ff  <= wa1_ff;
      wa3_ff  <= wa2_ff;
   end

   // configuration writes
   always_comb begin
      len_log2_in = len_log2_ff;
      level_in    = level_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_LENGTH_LOG2: len_log2_in = csr_wdata;
            REG_LEVEL:       level_in    = csr_wdata;
            default:         ;
         endcase
      end
   end

   // frame sequencer
   always_comb begin
      state_in     = state_ff;
      load_cnt_in  = load_cnt_ff;
      n_in         = n_ff;
      keep_in      = keep_ff;
      lv_in        = lv_ff;
      rnd_in       = rnd_ff;
      seg_in       = seg_ff;
      pair_in      = pair_ff;
      emit_in      = emit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_zero_in  = rsp_zero_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_err_in   = rsp_err_ff;

      unique case (state_ff)
         ST_LOAD: begin
            if (req_acc) begin
               load_cnt_in = load_cnt_ff + ADDR_W'(1);
            end
            if (frame_done) begin
               load_cnt_in = '0;
               n_in        = n_cur;
               keep_in     = n_cur >> level_ff;
               lv_in       = level_ff;
               rnd_in      = '0;
               seg_in      = ADDR_W'(n_cur >> 1);
               pair_in     = '0;
               emit_in     = '0;
               if (level_ff > lg_eff) begin
                  state_in = ST_ERR;
               end else if (level_ff == '0) begin
                  state_in = ST_EMIT;
               end else begin
                  state_in = ST_PASS;
               end
            end
         end
         ST_PASS: begin
            if (pass_issue) begin
               if (pair_ff == seg_ff - ADDR_W'(1)) begin
                  state_in = ST_DRAIN;
               end else begin
                  pair_in = pair_ff + ADDR_W'(1);
               end
            end
         end
         ST_DRAIN: begin
            // next round reads what this round wrote: wait until all writes land
            if (!pipe_busy) begin
               rnd_in  = rnd_ff + CFG_W'(1);
               seg_in  = seg_ff >> 1;
               pair_in = '0;
               if (rnd_ff + CFG_W'(1) == lv_ff) begin
                  state_in = ST_EMIT;
               end else begin
                  state_in = ST_PASS;
               end
            end
         end
         ST_EMIT: begin
            if (emit_issue) begin
               rsp_valid_in = 1'b1;
               rsp_err_in   = 1'b0;
               rsp_zero_in  = {1'b0, emit_ff} >= keep_ff;
               rsp_last_in  = {1'b0, emit_ff} == n_ff - CNT_W'(1);
               emit_in      = emit_ff + ADDR_W'(1);
               if ({1'b0, emit_ff} == n_ff - CNT_W'(1)) begin
                  state_in = ST_LOAD;
               end
            end
         end
         ST_ERR: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_err_in   = 1'b1;
               rsp_zero_in  = 1'b1;
               rsp_last_in  = 1'b1;
               state_in     = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         len_log2_ff  <= LENGTH_LOG2_RESET;
         level_ff     <= LEVEL_RESET;
         load_cnt_ff  <= '0;
         n_ff         <= '0;
         keep_ff      <= '0;
         lv_ff        <= '0;
         rnd_ff       <= '0;
         seg_ff       <= '0;
         pair_ff      <= '0;
         emit_ff      <= '0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rsp_zero_ff  <= 1'b0;
         rsp_last_ff  <= 1'b0;
         rsp_err_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_log2_ff  <= len_log2_in;
         level_ff     <= level_in;
         load_cnt_ff  <= load_cnt_in;
         n_ff         <= n_in;
         keep_ff      <= keep_in;
         lv_ff        <= lv_in;
         rnd_ff       <= rnd_in;
         seg_ff       <= seg_in;
         pair_ff      <= pair_in;
         emit_ff      <= emit_in;
         v1_ff        <= pass_issue;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         rsp_valid_ff <= rsp_valid_in;
         rsp_zero_ff  <= rsp_zero_in;
         rsp_last_ff  <= rsp_last_in;
         rsp_err_ff   <= rsp_err_in;
      end
   end

   // channel ports
   assign req_ch.ready       = (state_ff == ST_LOAD);
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.coefficient = (rsp_zero_ff || rsp_err_ff) ? '0 : rd_a_ff;
   assign rsp_ch.level_error = rsp_err_ff;
   assign rsp_ch.last        = rsp_last_ff;

endmodule

FILE: design/haar_chk.sv
`include "haar_dwt_approximation_unit_macros.svh"

module haar_chk
   import haar_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [COEF_W-1:0] rsp_coefficient,
   input logic              rsp_level_error,
   input logic              rsp_last
);

   // a stalled result word holds its payload
   `HAAR_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_coefficient) && $stable(rsp_last) && $stable(rsp_level_error))

   // a rejected frame gives one zero word that closes the frame
   `HAAR_ASSERT_IMP(a_err_word, clock, reset, rsp_valid && rsp_level_error,
      rsp_last && rsp_coefficient == '0)

   // inside a frame's output the words follow without gaps
   `HAAR_ASSERT_NXT(a_emit_burst, clock, reset, rsp_valid && rsp_ready && !rsp_last, rsp_valid)

   // no sample is taken while a frame is still being emitted
   `HAAR_ASSERT_IMP(a_no_load_mid_frame, clock, reset, rsp_valid && !rsp_last, !req_ready)

endmodule

bind haar_dwt_approximation_unit haar_chk u_haar_chk (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_ch.valid),
   .req_ready       (req_ch.ready),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_coefficient (rsp_ch.coefficient),
   .rsp_level_error (rsp_ch.level_error),
   .rsp_last        (rsp_ch.last)
);
